### hdl/kwl_pkg.sv
// ----------------------------------------------------------------------------
// kwl_pkg
// Shared widths, token kinds, token record and keyword lookup for the lexer.
// ----------------------------------------------------------------------------
package kwl_pkg;

  localparam int POSITION_BITS = 32;
  localparam int LENGTH_BITS   = 16;
  localparam int CHAR_W        = 8;
  localparam int KIND_W        = 5;
  localparam int START_W       = 32;
  localparam int LENGTH_W      = 16;
  localparam int PREFIX_BYTES  = 6;
  localparam int PREFIX_W      = PREFIX_BYTES * CHAR_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_ARROW_SINGLE, KIND_ARROW_DOUBLE, KIND_AMPERSAND, KIND_FALSE, KIND_TRUE,
    KIND_BRACE_OPEN, KIND_BRACE_CLOSE, KIND_BREAK, KIND_COMMA, KIND_ELSE,
    KIND_ENUM, KIND_END, KIND_EQUALS, KIND_FN, KIND_FOR, KIND_GREATER_THAN,
    KIND_IF, KIND_INTEGER, KIND_LET, KIND_LOOP, KIND_MATCH, KIND_MINUS,
    KIND_NIL, KIND_PAREN_OPEN, KIND_PAREN_CLOSE, KIND_PERIOD, KIND_SEMICOLON,
    KIND_STAR, KIND_STRING, KIND_STRUCT, KIND_SYMBOL, KIND_ERROR
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [START_W-1:0]   start;
    logic [LENGTH_W-1:0]  length;
    logic                 last;
  } token_t;

  // tokens produced by one byte, first in order
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } step_t;

  function automatic logic kw_is(input logic [PREFIX_W-1:0] prefix,
                                 input logic [LENGTH_BITS-1:0] len,
                                 input logic [PREFIX_W-1:0] word,
                                 input int unsigned chars);
    return (len == LENGTH_BITS'(chars)) && (prefix == word);
  endfunction

  function automatic kind_t kw_lookup(input logic [PREFIX_W-1:0] prefix,
                                      input logic [LENGTH_BITS-1:0] len,
                                      input logic overlong);
    kind_t k;
    k = KIND_SYMBOL;
    if (!overlong) begin
      if (kw_is(prefix, len, PREFIX_W'("break"), 5))  k = KIND_BREAK;
      if (kw_is(prefix, len, PREFIX_W'("else"), 4))   k = KIND_ELSE;
      if (kw_is(prefix, len, PREFIX_W'("enum"), 4))   k = KIND_ENUM;
      if (kw_is(prefix, len, PREFIX_W'("false"), 5))  k = KIND_FALSE;
      if (kw_is(prefix, len, PREFIX_W'("fn"), 2))     k = KIND_FN;
      if (kw_is(prefix, len, PREFIX_W'("for"), 3))    k = KIND_FOR;
      if (kw_is(prefix, len, PREFIX_W'("if"), 2))     k = KIND_IF;
      if (kw_is(prefix, len, PREFIX_W'("let"), 3))    k = KIND_LET;
      if (kw_is(prefix, len, PREFIX_W'("loop"), 4))   k = KIND_LOOP;
      if (kw_is(prefix, len, PREFIX_W'("match"), 5))  k = KIND_MATCH;
      if (kw_is(prefix, len, PREFIX_W'("nil"), 3))    k = KIND_NIL;
      if (kw_is(prefix, len, PREFIX_W'("struct"), 6)) k = KIND_STRUCT;
      if (kw_is(prefix, len, PREFIX_W'("true"), 4))   k = KIND_TRUE;
    end
    return k;
  endfunction

endpackage

### hdl/kwl_char_if.sv
// ----------------------------------------------------------------------------
// kwl_char_if
// Source byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface kwl_char_if import kwl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

### hdl/kwl_token_if.sv
// ----------------------------------------------------------------------------
// kwl_token_if
// Token channel: valid/ready handshake carrying kind, start, length, last flag.
// ----------------------------------------------------------------------------
interface kwl_token_if import kwl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   token_kind;
  logic [START_W-1:0]  token_start;
  logic [LENGTH_W-1:0] token_length;
  logic                last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input last_of_run, output ready);
endinterface

### hdl/kwl_scan.sv
// ----------------------------------------------------------------------------
// kwl_scan
// Scanner state and the per-byte next-state and token logic.
// ----------------------------------------------------------------------------
module kwl_scan import kwl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [CHAR_W-1:0] c,
  output step_t             step
);

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_INT, MODE_WORD, MODE_STR, MODE_ESC, MODE_MINUS, MODE_EQ
  } mode_t;

  localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;
  localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CH_AMP        = 8'h26;
  localparam logic [CHAR_W-1:0] CH_QUOTE      = 8'h27;
  localparam logic [CHAR_W-1:0] CH_LPAREN     = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN     = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR       = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_COMMA      = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PERIOD     = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SEMI       = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_EQUALS     = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_GREATER    = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_LBRACE     = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE     = 8'h7D;

  localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;
  localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LEN_TWO  = LENGTH_BITS'(2);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_PREFIX = LENGTH_BITS'(PREFIX_BYTES);

  mode_t                    mode, mode_next;
  logic [PREFIX_W-1:0]      prefix, prefix_next;
  logic                     overlong, overlong_next;
  logic [POSITION_BITS-1:0] start, start_next;
  logic [LENGTH_BITS-1:0]   length, length_next;
  logic [POSITION_BITS-1:0] position, position_next;

  logic                     is_digit, is_word, rescan;
  logic [LENGTH_BITS-1:0]   len_inc;
  logic                     a_v, b_v;
  kind_t                    a_kind, b_kind;
  logic [POSITION_BITS-1:0] a_start, b_start;
  logic [LENGTH_BITS-1:0]   a_len, b_len;
  token_t                   tok_a, tok_b;

  always_comb begin
    is_digit = c inside {[CH_ZERO:CH_NINE]};
    is_word  = c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z], CH_UNDERSCORE};
    len_inc  = (length == LEN_MAX) ? LEN_MAX : length + LEN_ONE;

    mode_next     = mode;
    prefix_next   = prefix;
    overlong_next = overlong;
    start_next    = start;
    length_next   = length;
    rescan        = 1'b0;
    a_v           = 1'b0;
    a_kind        = KIND_ERROR;
    a_start       = start;
    a_len         = length;
    b_v           = 1'b0;
    b_kind        = KIND_ERROR;
    b_start       = position;
    b_len         = LEN_ONE;

    // finish or extend the pending token
    case (mode)
      MODE_INT: begin
        if (is_digit) begin
          length_next = len_inc;
        end else begin
          a_v    = 1'b1;
          a_kind = KIND_INTEGER;
          rescan = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_word) begin
          if (length >= LEN_PREFIX) begin
            overlong_next = 1'b1;
          end else begin
            prefix_next = {prefix[PREFIX_W-CHAR_W-1:0], c};
          end
          length_next = len_inc;
        end else begin
          a_v    = 1'b1;
          a_kind = kw_lookup(prefix, length, overlong);
          rescan = 1'b1;
        end
      end
      MODE_MINUS, MODE_EQ: begin
        a_v = 1'b1;
        if (c == CH_GREATER) begin
          a_kind    = (mode == MODE_MINUS) ? KIND_ARROW_SINGLE : KIND_ARROW_DOUBLE;
          a_len     = LEN_TWO;
          mode_next = MODE_IDLE;
        end else begin
          a_kind = (mode == MODE_MINUS) ? KIND_MINUS : KIND_EQUALS;
          a_len  = LEN_ONE;
          rescan = 1'b1;
        end
      end
      MODE_STR: begin
        if (c == CH_NUL) begin
          a_v    = 1'b1;
          a_kind = KIND_ERROR;
          rescan = 1'b1;
        end else begin
          length_next = len_inc;
          if (c == CH_QUOTE) begin
            a_v       = 1'b1;
            a_kind    = KIND_STRING;
            a_len     = len_inc;
            mode_next = MODE_IDLE;
          end else if (c == CH_BACKSLASH) begin
            mode_next = MODE_ESC;
          end
        end
      end
      MODE_ESC: begin
        if (c == CH_NUL) begin
          a_v    = 1'b1;
          a_kind = KIND_ERROR;
          rescan = 1'b1;
        end else begin
          length_next = len_inc;
          if (c == CH_ZERO) begin
            mode_next = MODE_STR;
          end else begin
            a_v       = 1'b1;
            a_kind    = KIND_ERROR;
            a_len     = len_inc;
            mode_next = MODE_IDLE;
          end
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    // scan the byte from idle
    if (rescan) begin
      mode_next = MODE_IDLE;
      case (c)
        CH_SPACE, CH_NEWLINE: begin
        end
        CH_NUL: begin
          b_v    = 1'b1;
          b_kind = KIND_END;
          b_len  = LEN_ZERO;
        end
        CH_AMP:     begin b_v = 1'b1; b_kind = KIND_AMPERSAND;   end
        CH_LBRACE:  begin b_v = 1'b1; b_kind = KIND_BRACE_OPEN;  end
        CH_RBRACE:  begin b_v = 1'b1; b_kind = KIND_BRACE_CLOSE; end
        CH_COMMA:   begin b_v = 1'b1; b_kind = KIND_COMMA;       end
        CH_LPAREN:  begin b_v = 1'b1; b_kind = KIND_PAREN_OPEN;  end
        CH_RPAREN:  begin b_v = 1'b1; b_kind = KIND_PAREN_CLOSE; end
        CH_PERIOD:  begin b_v = 1'b1; b_kind = KIND_PERIOD;      end
        CH_SEMI:    begin b_v = 1'b1; b_kind = KIND_SEMICOLON;   end
        CH_STAR:    begin b_v = 1'b1; b_kind = KIND_STAR;        end
        default: begin
          if (c == CH_MINUS || c == CH_EQUALS || c == CH_QUOTE || is_digit || is_word) begin
            start_next    = position;
            length_next   = LEN_ONE;
            prefix_next   = '0;
            overlong_next = 1'b0;
            if (c == CH_MINUS) begin
              mode_next = MODE_MINUS;
            end else if (c == CH_EQUALS) begin
              mode_next = MODE_EQ;
            end else if (c == CH_QUOTE) begin
              mode_next = MODE_STR;
            end else if (is_digit) begin
              mode_next = MODE_INT;
            end else begin
              mode_next   = MODE_WORD;
              prefix_next = PREFIX_W'(c);
            end
          end else begin
            b_v    = 1'b1;
            b_kind = KIND_ERROR;
          end
        end
      endcase
    end

    // end of text clears everything
    if (c == CH_NUL) begin
      mode_next     = MODE_IDLE;
      prefix_next   = '0;
      overlong_next = 1'b0;
      start_next    = '0;
      length_next   = '0;
      position_next = '0;
    end else begin
      position_next = position + POSITION_BITS'(1);
    end

    tok_a.kind   = a_kind;
    tok_a.start  = START_W'(a_start);
    tok_a.length = LENGTH_W'(a_len);
    tok_a.last   = !b_v;
    tok_b.kind   = b_kind;
    tok_b.start  = START_W'(b_start);
    tok_b.length = LENGTH_W'(b_len);
    tok_b.last   = 1'b1;

    step.count  = {1'b0, a_v} + {1'b0, b_v};
    step.first  = a_v ? tok_a : tok_b;
    step.second = tok_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      prefix   <= '0;
      overlong <= 1'b0;
      start    <= '0;
      length   <= '0;
      position <= '0;
    end else if (take) begin
      mode     <= mode_next;
      prefix   <= prefix_next;
      overlong <= overlong_next;
      start    <= start_next;
      length   <= length_next;
      position <= position_next;
    end
  end

endmodule

### hdl/kwl_fifo.sv
// ----------------------------------------------------------------------------
// kwl_fifo
// Four-entry token queue: up to two writes per cycle, one read per cycle.
// ----------------------------------------------------------------------------
module kwl_fifo import kwl_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  step_t  wr,
  input  logic   pop,
  output token_t head,
  output logic   not_empty,
  output logic   room
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  token_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count, count_next;
  logic               do_pop;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign room      = (count <= CNT_W'(DEPTH - 2));
  assign do_pop    = pop && not_empty;

  always_comb begin
    count_next = count + CNT_W'(wr.count) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) begin
      mem[wr_ptr] <= wr.first;
    end
    if (wr.count == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= wr.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(wr.count);
      rd_ptr <= rd_ptr + PTR_W'(do_pop);
      count  <= count_next;
    end
  end

endmodule

### hdl/keyword_token_lexer.sv
// ----------------------------------------------------------------------------
// keyword_token_lexer
// Byte-serial lexer emitting keyword, symbol, integer, string and punctuator
// tokens as kind, start offset and length.
// ----------------------------------------------------------------------------
// One source byte is taken per clock cycle; each byte updates the scanner
// registers in the same cycle and pushes zero, one or two tokens into a
// four-entry token queue, whose head drives the token channel one transaction
// per cycle. Input is held off only while fewer than two queue entries are
// free, so a steady stream runs at one byte per cycle as long as the sink
// keeps up; a byte that closes one token and emits another queues two tokens
// that leave one at a time. Tokens pass through the registered queue first.
module keyword_token_lexer import kwl_pkg::*; (
  input logic        clk,
  input logic        rst,
  kwl_char_if.sink   chars,
  kwl_token_if.source tokens
);

  logic   take;
  step_t  step;
  token_t head;
  logic   not_empty;
  logic   room;

  assign chars.ready = room;
  assign take        = chars.valid && room;

  kwl_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .c    (chars.char_in),
    .step (step)
  );

  step_t wr;
  always_comb begin
    wr       = step;
    wr.count = take ? step.count : 2'd0;
  end

  kwl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .pop       (tokens.ready),
    .head      (head),
    .not_empty (not_empty),
    .room      (room)
  );

  assign tokens.valid        = not_empty;
  assign tokens.token_kind   = head.kind;
  assign tokens.token_start  = head.start;
  assign tokens.token_length = head.length;
  assign tokens.last_of_run  = head.last;

endmodule
